// ===== hdl/dad_pkg.sv =====
// ----------------------------------------------------------------------------
// dad_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ----------------------------------------------------------------------------
package dad_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int COUNT_W   = 16;
    localparam int QUOT_W    = 7;
    localparam int REM_W     = 7;
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 19;

    localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
    localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5243);
    localparam logic [REM_W-1:0]   CENTURY     = REM_W'(100);
    localparam logic [REM_W-1:0]   REM_LAST    = REM_W'(99);
    localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_APR   = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_JUN   = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_SEP   = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_NOV   = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAYS_LEAP   = DAY_W'(29);
    localparam logic [DAY_W-1:0]   DAYS_FEB    = DAY_W'(28);
    localparam logic [DAY_W-1:0]   DAYS_SHORT  = DAY_W'(30);
    localparam logic [DAY_W-1:0]   DAYS_LONG   = DAY_W'(31);

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [COUNT_W-1:0] day_count;
    } req_t;

    typedef struct packed {
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
        logic               year_overflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUOT,
        ST_REM,
        ST_CLAMP,
        ST_RUN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_QUOT,
        DP_REM,
        DP_CLAMP,
        DP_STEP,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic count_done;
        logic out_free;
    } status_t;

    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        priority if (month == MONTH_FEB)
            len = leap ? DAYS_LEAP : DAYS_FEB;
        else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV)
            len = DAYS_SHORT;
        else
            len = DAYS_LONG;
        return len;
    endfunction

endpackage

// ===== hdl/dad_dpath.sv =====
// ----------------------------------------------------------------------------
// dad_dpath
// Date registers, century tracking for the leap rule, day stepper and
// result register.
// ----------------------------------------------------------------------------
module dad_dpath
(
    input  logic           clk,
    input  logic           rst_n,
    input  dad_pkg::cmd_t  cmd,
    output dad_pkg::status_t status,
    input  dad_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dad_pkg::rsp_t  rsp
);
    import dad_pkg::*;

    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [COUNT_W-1:0] left_reg,  left_next;
    logic [REM_W-1:0]   r100_reg,  r100_next;
    logic [QUOT_W-1:0]  quot_reg,  quot_next;
    logic               ovf_reg,   ovf_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg,   rsp_next;

    logic [YEAR_W+RECIP_W-1:0] prod;
    logic [YEAR_W-1:0]         cent_years;
    logic                      leap;
    logic [DAY_W-1:0]          len;

    assign prod       = year_reg * RECIP_100;
    assign cent_years = YEAR_W'(quot_reg * CENTURY);
    assign leap       = (year_reg[1:0] == 2'b00) &&
                        ((r100_reg != '0) || (quot_reg[1:0] == 2'b00));
    assign len        = month_length(month_reg, leap);

    always_comb
    begin
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        left_next      = left_reg;
        r100_next      = r100_reg;
        quot_next      = quot_reg;
        ovf_next       = ovf_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        unique case (cmd.op)
            DP_HOLD:
            begin
            end
            DP_LOAD:
            begin
                day_next   = (req.start_day == '0) ? DAY_FIRST : req.start_day;
                month_next = (req.start_month == '0) ? MONTH_JAN :
                             (req.start_month > MONTH_DEC) ? MONTH_DEC : req.start_month;
                year_next  = (req.start_year > YEAR_MAX) ? YEAR_MAX : req.start_year;
                left_next  = req.day_count;
                ovf_next   = 1'b0;
            end
            DP_QUOT:
                quot_next = QUOT_W'(prod >> RECIP_SH);
            DP_REM:
                r100_next = REM_W'(year_reg - cent_years);
            DP_CLAMP:
                if (day_reg > len)
                    day_next = len;
            DP_STEP:
            begin
                left_next = left_reg - COUNT_W'(1);
                if (day_reg < len)
                    day_next = day_reg + DAY_W'(1);
                else
                begin
                    day_next = DAY_FIRST;
                    if (month_reg == MONTH_DEC)
                    begin
                        if (year_reg >= YEAR_MAX)
                        begin
                            day_next   = DAYS_LONG;
                            month_next = MONTH_DEC;
                            year_next  = YEAR_MAX;
                            left_next  = '0;
                            ovf_next   = 1'b1;
                        end
                        else
                        begin
                            month_next = MONTH_JAN;
                            year_next  = year_reg + YEAR_W'(1);
                            if (r100_reg == REM_LAST)
                            begin
                                r100_next = '0;
                                quot_next = quot_reg + QUOT_W'(1);
                            end
                            else
                                r100_next = r100_reg + REM_W'(1);
                        end
                    end
                    else
                        month_next = month_reg + MONTH_W'(1);
                end
            end
            DP_EMIT:
            begin
                rsp_next.end_day       = day_reg;
                rsp_next.end_month     = month_reg;
                rsp_next.end_year      = year_reg;
                rsp_next.year_overflow = ovf_reg;
                rsp_valid_next         = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= DAY_FIRST;
            month_reg     <= MONTH_JAN;
            year_reg      <= '0;
            left_reg      <= '0;
            r100_reg      <= '0;
            quot_reg      <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            left_reg      <= left_next;
            r100_reg      <= r100_next;
            quot_reg      <= quot_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign status.count_done = (left_reg == '0);
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid         = rsp_valid_reg;
    assign rsp               = rsp_reg;

    a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_STEP |=> (left_reg == $past(left_reg) - COUNT_W'(1)) || ovf_reg)
        else $error("day count did not advance on step");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        r100_reg < CENTURY)
        else $error("year remainder out of range");

    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (day_reg == DAYS_LONG && month_reg == MONTH_DEC && year_reg == YEAR_MAX))
        else $error("overflow without saturated date");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_EMIT |=> rsp_valid_reg && rsp_reg.end_year <= YEAR_MAX)
        else $error("result not registered on emit");

endmodule

// ===== hdl/dad_ctrl.sv =====
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer: load, century split, day clamp, day stepping, result hand-off.
// ----------------------------------------------------------------------------
module dad_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  dad_pkg::status_t status,
    output dad_pkg::cmd_t    cmd
);
    import dad_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_HOLD;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                cmd.op     = DP_QUOT;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.op     = DP_REM;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.op     = DP_CLAMP;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.count_done)
                    state_next = ST_EMIT;
                else
                    cmd.op = DP_STEP;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("request taken while busy");

    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_LOAD |=> state_reg == ST_QUOT)
        else $error("load not followed by quotient stage");

endmodule

// ===== hdl/date_add_days.sv =====
// ----------------------------------------------------------------------------
// date_add_days
// Gregorian date plus a day count, advanced one day per clock.
// The day stepper advances one day a cycle and the sequencer handles one
// date at a time.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module date_add_days
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dad_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dad_pkg::rsp_t rsp
);
    import dad_pkg::*;

    cmd_t    cmd;
    status_t status;

    dad_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dad_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== test/tb_date_add_days.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_add_days
// Self-checking bench for the Gregorian day adder. Each request transaction
// is predicted in the bench itself, by skipping whole months through the
// calendar, and the result is queued. Every result transaction is compared
// field by field with the oldest queued date. Directed cases cover zero
// counts, out-of-range clean-up, month ends, leap rules and saturation at
// the last year. Random requests follow under four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_date_add_days;
    import dad_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    rsp_t        dates_due[$];
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned sent = 0;
    int unsigned overflows = 0;
    int unsigned cycles = 0;

    date_add_days dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, dates_due.size());
            $display("tb_date_add_days: errors");
            $finish;
        end
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m,
                                                  input int unsigned y);
        if (m == MONTH_FEB)
            return leap_year(y) ? DAYS_LEAP : DAYS_FEB;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return DAYS_SHORT;
        return DAYS_LONG;
    endfunction

    function automatic rsp_t advance_date(input req_t r);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned left;
        int unsigned len;
        int unsigned room;
        rsp_t        res;
        d = r.start_day;
        m = r.start_month;
        y = r.start_year;
        left = r.day_count;
        res.year_overflow = 1'b0;
        if (m < MONTH_JAN)
            m = MONTH_JAN;
        if (m > MONTH_DEC)
            m = MONTH_DEC;
        if (y > YEAR_MAX)
            y = YEAR_MAX;
        len = days_in_month(m, y);
        if (d < DAY_FIRST)
            d = DAY_FIRST;
        if (d > len)
            d = len;
        while (left > 0)
        begin
            len = days_in_month(m, y);
            room = len - d;
            if (left <= room)
            begin
                d = d + left;
                left = 0;
            end
            else
            begin
                left = left - room - 1;
                d = DAY_FIRST;
                if (m == MONTH_DEC)
                begin
                    if (y >= YEAR_MAX)
                    begin
                        d = DAYS_LONG;
                        y = YEAR_MAX;
                        left = 0;
                        res.year_overflow = 1'b1;
                    end
                    else
                    begin
                        m = MONTH_JAN;
                        y = y + 1;
                    end
                end
                else
                    m = m + 1;
            end
        end
        res.end_day = DAY_W'(d);
        res.end_month = MONTH_W'(m);
        res.end_year = YEAR_W'(y);
        return res;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (dates_due.size() == 0)
                flag_error($sformatf("unrequested result %0d/%0d/%0d overflow %0b",
                                     rsp.end_day, rsp.end_month, rsp.end_year,
                                     rsp.year_overflow));
            else
            begin
                want = dates_due.pop_front();
                if (rsp.end_day !== want.end_day || rsp.end_month !== want.end_month ||
                    rsp.end_year !== want.end_year ||
                    rsp.year_overflow !== want.year_overflow)
                    flag_error($sformatf(
                        "got %0d/%0d/%0d overflow %0b, expected %0d/%0d/%0d overflow %0b",
                        rsp.end_day, rsp.end_month, rsp.end_year, rsp.year_overflow,
                        want.end_day, want.end_month, want.end_year, want.year_overflow));
            end
        end
    end

    task automatic send_date(input int unsigned day, input int unsigned month,
                             input int unsigned year, input int unsigned count);
        req_t item;
        rsp_t want;
        item.start_day = DAY_W'(day);
        item.start_month = MONTH_W'(month);
        item.start_year = YEAR_W'(year);
        item.day_count = COUNT_W'(count);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        want = advance_date(item);
        dates_due.push_back(want);
        sent++;
        if (want.year_overflow)
            overflows++;
    endtask

    task automatic test_zero_count;
        send_date(15, 6, 2024, 0);
        send_date(1, 1, 0, 0);
        send_date(31, 12, 9999, 0);
    endtask

    task automatic test_range_cleanup;
        send_date(31, 2, 2023, 0);
        send_date(0, 0, 5, 0);
        send_date(31, 15, 16383, 0);
        send_date(31, 2, 2023, 1);
        send_date(31, 4, 1999, 1);
        send_date(0, 13, 12000, 3);
    endtask

    task automatic test_month_ends;
        send_date(28, 2, 2024, 1);
        send_date(28, 2, 1900, 1);
        send_date(28, 2, 2000, 1);
        send_date(28, 2, 0, 1);
        send_date(30, 4, 2021, 1);
        send_date(31, 12, 1999, 1);
        send_date(1, 1, 2020, 366);
    endtask

    task automatic test_year_overflow;
        send_date(31, 12, 9999, 1);
        send_date(1, 1, 9999, 364);
        send_date(1, 1, 9999, 365);
    endtask

    task automatic test_long_counts;
        send_date(1, 1, 0, 65535);
        send_date(1, 1, 9990, 65535);
        send_date(31, 15, 16383, 65535);
    endtask

    task automatic test_random_dates(input int unsigned n, input int unsigned idle,
                                     input int unsigned stall);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned count;
        int unsigned pick;
        idle_pct = idle;
        stall_pct = stall;
        repeat (n)
        begin
            day = ($urandom_range(99) < 8) ? 0 : $urandom_range(31, 1);
            month = ($urandom_range(99) < 10) ? $urandom_range(15, 0)
                                               : $urandom_range(12, 1);
            pick = $urandom_range(99);
            if (pick < 15)
                year = $urandom_range(16383, 9990);
            else if (pick < 22)
                year = $urandom_range(16383, 0);
            else
                year = $urandom_range(9999, 0);
            pick = $urandom_range(99);
            if (pick < 4)
                count = $urandom_range(65535, 0);
            else if (pick < 9)
                count = 0;
            else if (pick < 22)
                count = $urandom_range(4000, 0);
            else
                count = $urandom_range(500, 0);
            send_date(day, month, year, count);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_count();
        test_range_cleanup();
        test_month_ends();
        test_year_overflow();
        test_long_counts();
        test_random_dates(20, 0, 0);
        test_random_dates(20, 84, 0);
        test_random_dates(20, 0, 84);
        test_random_dates(20, 29, 29);
        req_valid <= 1'b0;

        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("%0d date transactions checked, %0d saturating at the last year,",
                 sent, overflows);
        $display("with directed edge cases and four sender idle / receiver stall mixes");
        if (mismatches == 0)
            $display("tb_date_add_days: clean");
        else
            $display("tb_date_add_days: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dad_pkg.sv
hdl/dad_dpath.sv
hdl/dad_ctrl.sv
hdl/date_add_days.sv
test/tb_date_add_days.sv
